// ----- sv/vnpo_pkg.sv -----
// Shared types, constants and the cosine weight function for the
// value noise pixel overlay. Depends on nothing; every module imports it.
`default_nettype none

package vnpo_pkg;

  localparam int unsigned DEF_MAX_OCTAVES    = 8;
  localparam int unsigned DEF_COORD_BITS     = 12;
  localparam int unsigned DEF_COS_TABLE_BITS = 8;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned OCT_W   = 4;
  localparam int unsigned NOISE_W = 32;
  localparam int unsigned ACC_W   = 36;
  localparam int unsigned PTR_W   = 4;
  localparam int unsigned LAT_N   = 16;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [SIZE_W-1:0] RST_WIDTH   = 13'd256;
  localparam logic [SIZE_W-1:0] RST_HEIGHT  = 13'd256;
  localparam logic [INV_W-1:0]  RST_INV     = 24'd4096;
  localparam logic [OCT_W-1:0]  RST_OCTAVES = 4'd4;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam int unsigned HASH_SHIFT = 13;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic signed [NOISE_W-1:0] NOISE_ONE = 32'sh4000_0000;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_INV_X   = 3'd2,
    REG_INV_Y   = 3'd3,
    REG_OCTAVES = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    BL_IDLE,
    BL_ROW0,
    BL_ROW1,
    BL_ROW1_DONE,
    BL_COL,
    BL_COL_DONE
  } blend_ph_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_OCT,
    ST_HASH,
    ST_DRAIN,
    ST_SMOOTH,
    ST_BLEND,
    ST_ACC,
    ST_LEVEL
  } state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] in_chan0;
    logic [CHAN_W-1:0] in_chan1;
    logic [CHAN_W-1:0] in_chan2;
    logic [CHAN_W-1:0] in_chan3;
  } in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
    logic [CHAN_W-1:0] out_chan3;
    logic [CHAN_W-1:0] noise_level;
    logic              frame_end;
  } out_t;

  typedef struct packed {
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
    logic [INV_W-1:0]  inv_wavelength_x;
    logic [INV_W-1:0]  inv_wavelength_y;
    logic [OCT_W-1:0]  octave_count;
  } cfg_t;

  typedef struct packed {
    logic             load_pix;
    logic             acc_clr;
    logic             oct_setup;
    logic             hash_issue;
    logic [PTR_W-1:0] hash_idx;
    logic             smooth;
    blend_ph_e        blend_ph;
    logic             acc_en;
    logic [OCT_W-1:0] oct_k;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic hash_busy;
  } status_t;

  // Q0.16 weight (1-cos(pi*i/N))/2 built as sin^2 from a Q30 series
  function automatic logic [15:0] cos_weight(input longint unsigned i,
                                             input int unsigned tbits);
    longint unsigned phi;
    longint unsigned phi2;
    longint unsigned term;
    longint unsigned w;
    longint          s;
    phi  = (64'd3373259426 * i + (64'd1 << tbits)) >> (tbits + 1);
    phi2 = (phi * phi) >> 30;
    term = phi;
    s    = longint'(phi);
    term = ((term * phi2) >> 30) / 6;   s = s - longint'(term);
    term = ((term * phi2) >> 30) / 20;  s = s + longint'(term);
    term = ((term * phi2) >> 30) / 42;  s = s - longint'(term);
    term = ((term * phi2) >> 30) / 72;  s = s + longint'(term);
    term = ((term * phi2) >> 30) / 110; s = s - longint'(term);
    term = ((term * phi2) >> 30) / 156; s = s + longint'(term);
    term = ((term * phi2) >> 30) / 210; s = s - longint'(term);
    term = ((term * phi2) >> 30) / 272; s = s + longint'(term);
    term = ((term * phi2) >> 30) / 342; s = s - longint'(term);
    term = ((term * phi2) >> 30) / 420; s = s + longint'(term);
    if (s < 0) begin
      s = 0;
    end
    w = (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
    return (w > 64'd65535) ? 16'hffff : w[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/value_noise_pixel_overlay_unit.sv -----
// Top level of the value noise pixel overlay: register file, sequencer
// and datapath. Depends on vnpo_pkg, vnpo_regs, vnpo_ctrl, vnpo_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   in       | in_valid_i/in_ready_o | in_data_i  (in_t)
//   out      | out_valid_o/out_ready_i | out_data_o (out_t)
//   config   | psel/penable/pwrite  | paddr, pwdata, prdata
//
// The work per word is set by the 16 lattice hashes per octave through the
// single hash pipeline.
// A finished word sits in the output register; the next word is taken
// while it waits, and only its final load stalls on a full output register.
// Reset clears the raster counters, sequencer and valids; registers reload
// their defaults.
`default_nettype none

module value_noise_pixel_overlay_unit import vnpo_pkg::*; #(
  parameter int unsigned MAX_OCTAVES    = DEF_MAX_OCTAVES,
  parameter int unsigned COORD_BITS     = DEF_COORD_BITS,
  parameter int unsigned COS_TABLE_BITS = DEF_COS_TABLE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  vnpo_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vnpo_ctrl #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vnpo_dp #(
    .COORD_BITS     (COORD_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ----- sv/vnpo_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on vnpo_pkg.
`default_nettype none

module vnpo_regs import vnpo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH:   cfg_d.image_width      = pwdata[SIZE_W-1:0];
        REG_HEIGHT:  cfg_d.image_height     = pwdata[SIZE_W-1:0];
        REG_INV_X:   cfg_d.inv_wavelength_x = pwdata[INV_W-1:0];
        REG_INV_Y:   cfg_d.inv_wavelength_y = pwdata[INV_W-1:0];
        REG_OCTAVES: cfg_d.octave_count     = pwdata[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:   prdata = PDATA_W'(cfg_q.image_width);
      REG_HEIGHT:  prdata = PDATA_W'(cfg_q.image_height);
      REG_INV_X:   prdata = PDATA_W'(cfg_q.inv_wavelength_x);
      REG_INV_Y:   prdata = PDATA_W'(cfg_q.inv_wavelength_y);
      REG_OCTAVES: prdata = PDATA_W'(cfg_q.octave_count);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= RST_WIDTH;
      cfg_q.image_height     <= RST_HEIGHT;
      cfg_q.inv_wavelength_x <= RST_INV;
      cfg_q.inv_wavelength_y <= RST_INV;
      cfg_q.octave_count     <= RST_OCTAVES;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/vnpo_ctrl.sv -----
// Sequencer: walks one word through octaves, lattice hashing, smoothing
// and blending, and owns the handshakes. Depends on vnpo_pkg.
`default_nettype none

module vnpo_ctrl import vnpo_pkg::*; #(
  parameter int unsigned MAX_OCTAVES = DEF_MAX_OCTAVES
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e           state_q, state_d;
  blend_ph_e        bl_q, bl_d;
  logic [OCT_W-1:0] k_q, k_d;
  logic [PTR_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [OCT_W-1:0] oct_eff;

  assign oct_eff = (cfg_i.octave_count > OCT_W'(MAX_OCTAVES)) ?
                   OCT_W'(MAX_OCTAVES) : cfg_i.octave_count;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    bl_d       = bl_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o          = '0;
    cmd_o.blend_ph = BL_IDLE;
    cmd_o.oct_k    = k_q;
    cmd_o.hash_idx = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_pix = 1'b1;
          state_d        = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.acc_clr = 1'b1;
        k_d           = '0;
        state_d       = (oct_eff == '0) ? ST_LEVEL : ST_OCT;
      end
      ST_OCT: begin
        cmd_o.oct_setup = 1'b1;
        cnt_d           = '0;
        state_d         = ST_HASH;
      end
      ST_HASH: begin
        cmd_o.hash_issue = 1'b1;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.hash_busy) begin
          state_d = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        bl_d         = BL_ROW0;
        state_d      = ST_BLEND;
      end
      ST_BLEND: begin
        cmd_o.blend_ph = bl_q;
        unique case (bl_q)
          BL_ROW0:      bl_d = BL_ROW1;
          BL_ROW1:      bl_d = BL_ROW1_DONE;
          BL_ROW1_DONE: bl_d = BL_COL;
          BL_COL:       bl_d = BL_COL_DONE;
          default: begin
            bl_d    = BL_IDLE;
            state_d = ST_ACC;
          end
        endcase
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        k_d          = k_q + 1'b1;
        state_d      = (k_q + 1'b1 == oct_eff) ? ST_LEVEL : ST_OCT;
      end
      ST_LEVEL: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bl_q        <= BL_IDLE;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bl_q        <= bl_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/vnpo_dp.sv -----
// Datapath: raster counters, coordinate products, pipelined lattice hash,
// 3x3 smoothing, shared blend multiplier, octave sum and output register.
// Depends on vnpo_pkg.
`default_nettype none

module vnpo_dp import vnpo_pkg::*; #(
  parameter int unsigned COORD_BITS     = DEF_COORD_BITS,
  parameter int unsigned COS_TABLE_BITS = DEF_COS_TABLE_BITS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  in_t     in_data_i,
  output out_t    out_data_o
);

  localparam int unsigned PROD_W = COORD_BITS + INV_W;
  localparam int unsigned COS_N  = 1 << COS_TABLE_BITS;
  localparam int unsigned SM_W   = NOISE_W + 4;
  localparam int unsigned MUL_W  = NOISE_W + 18;

  // weight table
  logic [15:0] cos_tab [COS_N];
  for (genvar gi = 0; gi < COS_N; gi++) begin : g_cos
    localparam logic [15:0] W = cos_weight(64'(gi), COS_TABLE_BITS);
    assign cos_tab[gi] = W;
  end

  // raster position
  logic [COORD_BITS-1:0] wm1, hm1, col_q, row_q, col_c, row_c;
  logic [PROD_W-1:0]     prodx_q, prody_q;
  logic                  frame_q;
  in_t                   pix_q;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      wm1 = '0;
    end else if (32'(cfg_i.image_width) > (32'd1 << COORD_BITS)) begin
      wm1 = '1;
    end else begin
      wm1 = COORD_BITS'(cfg_i.image_width - 1'b1);
    end
    if (cfg_i.image_height == '0) begin
      hm1 = '0;
    end else if (32'(cfg_i.image_height) > (32'd1 << COORD_BITS)) begin
      hm1 = '1;
    end else begin
      hm1 = COORD_BITS'(cfg_i.image_height - 1'b1);
    end
  end

  assign col_c = (col_q > wm1) ? wm1 : col_q;
  assign row_c = (row_q > hm1) ? hm1 : row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load_pix) begin
      if (col_c == wm1) begin
        col_q <= '0;
        row_q <= (row_c == hm1) ? '0 : row_c + 1'b1;
      end else begin
        col_q <= col_c + 1'b1;
        row_q <= row_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      prodx_q <= PROD_W'(col_c) * PROD_W'(cfg_i.inv_wavelength_x);
      prody_q <= PROD_W'(row_c) * PROD_W'(cfg_i.inv_wavelength_y);
      frame_q <= (col_c == wm1) && (row_c == hm1);
      pix_q   <= in_data_i;
    end
  end

  // per-octave lattice origin and weights
  logic [63:0] pxs, pys;
  logic [31:0] ix_q, iy_q;
  logic [15:0] wx_q, wy_q;

  assign pxs = 64'(prodx_q) << cmd_i.oct_k;
  assign pys = 64'(prody_q) << cmd_i.oct_k;

  always_ff @(posedge clk_i) begin
    if (cmd_i.oct_setup) begin
      ix_q <= pxs[47:16];
      iy_q <= pys[47:16];
      wx_q <= cos_tab[pxs[15 -: COS_TABLE_BITS]];
      wy_q <= cos_tab[pys[15 -: COS_TABLE_BITS]];
    end
  end

  // hash pipeline over the 4x4 grid around the origin
  logic [31:0] hx, hy, hn0, hn1, ht;
  logic [31:0] h1_n_q, h2_n_q, h2_p_q, h3_n_q, h3_q_q;
  logic        h1_v_q, h2_v_q, h3_v_q;
  logic signed [NOISE_W-1:0] lat_new;
  logic signed [NOISE_W-1:0] lat_q [LAT_N];

  assign hx  = ix_q + 32'(cmd_i.hash_idx[1:0]) - 32'd1;
  assign hy  = iy_q + 32'(cmd_i.hash_idx[3:2]) - 32'd1;
  assign hn0 = hx + hy * HASH_MUL_Y;
  assign hn1 = (hn0 << HASH_SHIFT) ^ hn0;
  assign ht  = h3_n_q * h3_q_q + HASH_C3;
  assign lat_new = NOISE_ONE - $signed({1'b0, ht[30:0]});
  assign status_o.hash_busy = h1_v_q || h2_v_q || h3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
      h3_v_q <= 1'b0;
    end else begin
      h1_v_q <= cmd_i.hash_issue;
      h2_v_q <= h1_v_q;
      h3_v_q <= h2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_n_q <= hn1;
    h2_n_q <= h1_n_q;
    h2_p_q <= h1_n_q * h1_n_q;
    h3_n_q <= h2_n_q;
    h3_q_q <= h2_p_q * HASH_C1 + HASH_C2;
    if (h3_v_q) begin
      for (int j = 0; j < LAT_N - 1; j++) begin
        lat_q[j] <= lat_q[j+1];
      end
      lat_q[LAT_N-1] <= lat_new;
    end
  end

  // 3x3 smoothing at the four cell corners, all at once
  logic signed [SM_W-1:0]    sm_sum [4];
  logic signed [NOISE_W-1:0] sm_q   [4];

  for (genvar g = 0; g < 4; g++) begin : g_smooth
    localparam int C = (1 + g / 2) * 4 + (1 + g % 2);
    assign sm_sum[g] = SM_W'(lat_q[C-5]) + SM_W'(lat_q[C-3])
                     + SM_W'(lat_q[C+3]) + SM_W'(lat_q[C+5])
                     + ((SM_W'(lat_q[C-1]) + SM_W'(lat_q[C+1])
                       + SM_W'(lat_q[C-4]) + SM_W'(lat_q[C+4])) <<< 1)
                     + (SM_W'(lat_q[C]) <<< 2);
    always_ff @(posedge clk_i) begin
      if (cmd_i.smooth) begin
        sm_q[g] <= NOISE_W'(sm_sum[g] >>> 4);
      end
    end
  end

  // blend: a + floor((b-a)*w / 2^16), one multiplier, registered product
  logic signed [NOISE_W-1:0] op_a, op_b, ba_q, bres, i1_q, i2_q, nz_q;
  logic [15:0]               op_w;
  logic signed [NOISE_W:0]   bdiff;
  logic signed [MUL_W-1:0]   bprod_q;

  always_comb begin
    case (cmd_i.blend_ph)
      BL_ROW1: begin
        op_a = sm_q[2];
        op_b = sm_q[3];
        op_w = wx_q;
      end
      BL_COL: begin
        op_a = i1_q;
        op_b = i2_q;
        op_w = wy_q;
      end
      default: begin
        op_a = sm_q[0];
        op_b = sm_q[1];
        op_w = wx_q;
      end
    endcase
  end

  assign bdiff = (NOISE_W+1)'(op_b) - (NOISE_W+1)'(op_a);
  assign bres  = ba_q + NOISE_W'(bprod_q >>> 16);

  always_ff @(posedge clk_i) begin
    ba_q    <= op_a;
    bprod_q <= MUL_W'(bdiff) * MUL_W'($signed({1'b0, op_w}));
    case (cmd_i.blend_ph)
      BL_ROW1:      i1_q <= bres;
      BL_ROW1_DONE: i2_q <= bres;
      BL_COL_DONE:  nz_q <= bres;
      default: ;
    endcase
  end

  // octave sum, clamp and byte mapping
  logic signed [ACC_W-1:0] acc_q, clamp;
  logic [31:0]             lvl_u;
  logic [39:0]             lvl_m;
  logic [CHAN_W-1:0]       level;
  out_t                    out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(nz_q >>> cmd_i.oct_k);
    end
  end

  always_comb begin
    if (acc_q > ACC_W'(NOISE_ONE)) begin
      clamp = ACC_W'(NOISE_ONE);
    end else if (acc_q < -ACC_W'(NOISE_ONE)) begin
      clamp = -ACC_W'(NOISE_ONE);
    end else begin
      clamp = acc_q;
    end
  end

  assign lvl_u = 32'(clamp + ACC_W'(NOISE_ONE));
  assign lvl_m = 40'(lvl_u) * 40'd255;
  assign level = lvl_m[38:31];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_chan0   <= pix_q.in_chan0 + level;
      out_q.out_chan1   <= pix_q.in_chan1 + level;
      out_q.out_chan2   <= pix_q.in_chan2 + level;
      out_q.out_chan3   <= pix_q.in_chan3;
      out_q.noise_level <= level;
      out_q.frame_end   <= frame_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- sv/vnpo_checker.sv -----
// Port-level checks on the overlay top, attached by bind.
// Depends on vnpo_pkg and value_noise_pixel_overlay_unit.
`default_nettype none

module vnpo_checker import vnpo_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input in_t                in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_t               out_data_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // port never inserts wait states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");

  // one word at a time: after a take, input closes for the work
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after take");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("out dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out word changed");

endmodule

bind value_noise_pixel_overlay_unit vnpo_checker u_vnpo_checker (.*);

`default_nettype wire

// ----- bench/value_noise_pixel_overlay_unit_tb.sv -----
// Testbench for value_noise_pixel_overlay_unit: drives pixel words, predicts
// noise level, raster position and frame end per word. Depends on vnpo_pkg.
`timescale 1ns / 100ps

module value_noise_pixel_overlay_unit_tb;
  import vnpo_pkg::*;

  localparam int unsigned OCT_MAX  = DEF_MAX_OCTAVES;
  localparam int unsigned CRD_BITS = DEF_COORD_BITS;
  localparam int unsigned TBL_BITS = DEF_COS_TABLE_BITS;
  localparam longint CYCLE_LIMIT   = 64'd2_500_000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_t               out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  value_noise_pixel_overlay_unit dut (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] wt_tbl [1 << TBL_BITS];
  logic [SIZE_W-1:0] cfg_w, cfg_h;
  logic [INV_W-1:0]  cfg_ix, cfg_iy;
  logic [OCT_W-1:0]  cfg_oct;
  int unsigned       col_pos, row_pos;

  out_t   pending_words[$];
  int     fail_cnt;
  int     word_cnt;
  longint cyc;
  int     src_idle_pct, snk_idle_pct;

  function automatic longint lattice_val(logic [31:0] x, logic [31:0] y);
    logic [31:0] n, t;
    n = x + y * HASH_MUL_Y;
    n = (n << HASH_SHIFT) ^ n;
    t = n * (n * n * HASH_C1 + HASH_C2) + HASH_C3;
    return 64'sh4000_0000 - longint'({33'd0, t[30:0]});
  endfunction

  function automatic longint smooth_val(logic [31:0] x, logic [31:0] y);
    longint c, s;
    c = lattice_val(x - 1, y - 1) + lattice_val(x + 1, y - 1)
      + lattice_val(x - 1, y + 1) + lattice_val(x + 1, y + 1);
    s = lattice_val(x - 1, y) + lattice_val(x + 1, y)
      + lattice_val(x, y - 1) + lattice_val(x, y + 1);
    return (c + 2 * s + 4 * lattice_val(x, y)) >>> 4;
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return (a * (65536 - w) + b * w) >>> 16;
  endfunction

  function automatic longint octave_val(logic [63:0] px, logic [63:0] py);
    logic [31:0] ix, iy;
    longint wx, wy, top, bot;
    ix  = px[47:16];
    iy  = py[47:16];
    wx  = wt_tbl[px[15:16-TBL_BITS]];
    wy  = wt_tbl[py[15:16-TBL_BITS]];
    top = mix(smooth_val(ix, iy), smooth_val(ix + 1, iy), wx);
    bot = mix(smooth_val(ix, iy + 1), smooth_val(ix + 1, iy + 1), wx);
    return mix(top, bot, wy);
  endfunction

  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v);
    if (v < 1) return 1;
    if (v > (1 << CRD_BITS)) return 1 << CRD_BITS;
    return v;
  endfunction

  // independent build of the Q0.16 weight table from the Q30 sine series
  function automatic logic [15:0] cos_weight_tb(int unsigned i);
    longint unsigned phi, phi2, term, w;
    longint s;
    phi  = (64'd3373259426 * i + (64'd1 << TBL_BITS)) / (64'd2 << TBL_BITS);
    phi2 = (phi * phi) >> 30;
    term = phi;
    s    = phi;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * phi2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - term;
      else s = s + term;
    end
    if (s < 0) s = 0;
    w = (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
    return (w > 65535) ? 16'hffff : w[15:0];
  endfunction

  // computes the overlaid word and advances the raster position
  function automatic out_t overlay_pixel(in_t px);
    int unsigned w, h, oct, c, r;
    longint sum;
    logic [63:0] lv, ax, ay;
    out_t o;
    w   = clamp_size(cfg_w);
    h   = clamp_size(cfg_h);
    oct = (cfg_oct > OCT_MAX) ? OCT_MAX : cfg_oct;
    c   = (col_pos >= w) ? w - 1 : col_pos;
    r   = (row_pos >= h) ? h - 1 : row_pos;
    sum = 0;
    for (int k = 0; k < oct; k++) begin
      ax  = (64'(c) * 64'(cfg_ix)) << k;
      ay  = (64'(r) * 64'(cfg_iy)) << k;
      sum = sum + (octave_val(ax, ay) >>> k);
    end
    if (sum > 64'sh4000_0000) sum = 64'sh4000_0000;
    if (sum < -64'sh4000_0000) sum = -64'sh4000_0000;
    lv = (64'(sum + 64'sh4000_0000) * 255) >> 31;
    o.noise_level = lv[7:0];
    o.out_chan0   = px.in_chan0 + lv[7:0];
    o.out_chan1   = px.in_chan1 + lv[7:0];
    o.out_chan2   = px.in_chan2 + lv[7:0];
    o.out_chan3   = px.in_chan3;
    o.frame_end   = (c == w - 1) && (r == h - 1);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH word %0d %s: got %0h want %0h", word_cnt, what, got, want);
    fail_cnt++;
  endtask

  // output side: random stall, compare each word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected word", int'(out_data_o.noise_level), 0);
        end else begin
          out_t e;
          e = pending_words.pop_front();
          if (out_data_o.out_chan0 != e.out_chan0)
            report_mismatch("out_chan0", out_data_o.out_chan0, e.out_chan0);
          if (out_data_o.out_chan1 != e.out_chan1)
            report_mismatch("out_chan1", out_data_o.out_chan1, e.out_chan1);
          if (out_data_o.out_chan2 != e.out_chan2)
            report_mismatch("out_chan2", out_data_o.out_chan2, e.out_chan2);
          if (out_data_o.out_chan3 != e.out_chan3)
            report_mismatch("out_chan3", out_data_o.out_chan3, e.out_chan3);
          if (out_data_o.noise_level != e.noise_level)
            report_mismatch("noise_level", out_data_o.noise_level, e.noise_level);
          if (out_data_o.frame_end != e.frame_end)
            report_mismatch("frame_end", out_data_o.frame_end, e.frame_end);
        end
        word_cnt++;
      end
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cyc);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH:   cfg_w   = val[SIZE_W-1:0];
      REG_HEIGHT:  cfg_h   = val[SIZE_W-1:0];
      REG_INV_X:   cfg_ix  = val[INV_W-1:0];
      REG_INV_Y:   cfg_iy  = val[INV_W-1:0];
      REG_OCTAVES: cfg_oct = val[OCT_W-1:0];
      default: ;
    endcase
  endtask

  // valid drops only when idling or draining, so back-to-back words
  // see a single update at the accepting edge
  task automatic send_pixel(in_t px, bit check_fixed, logic [7:0] want_lvl);
    out_t e;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    e = overlay_pixel(px);
    if (check_fixed && e.noise_level != want_lvl)
      report_mismatch("table level", e.noise_level, want_lvl);
    pending_words.push_back(e);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  typedef struct {
    in_t        px;
    bit         fixed;
    logic [7:0] lvl;
  } stim_row_t;

  stim_row_t dir_rows[$];

  initial begin
    in_t px;
    int phase_len;
    fail_cnt = 0; word_cnt = 0; cyc = 0;
    src_idle_pct = 23; snk_idle_pct = 56;
    for (int i = 0; i < (1 << TBL_BITS); i++) wt_tbl[i] = cos_weight_tb(i);
    cfg_w = RST_WIDTH; cfg_h = RST_HEIGHT; cfg_ix = RST_INV; cfg_iy = RST_INV;
    cfg_oct = RST_OCTAVES; col_pos = 0; row_pos = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: channel extremes under reset config
    dir_rows.push_back('{'{8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0});
    dir_rows.push_back('{'{8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, 8'd0});
    dir_rows.push_back('{'{8'h55, 8'haa, 8'h0f, 8'hf0}, 1'b0, 8'd0});
    foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].fixed, dir_rows[i].lvl);
    wait_drained();

    // zero octaves gives mid grey; tiny frame to hit frame end and wrap
    reg_write(REG_OCTAVES, 0);
    reg_write(REG_WIDTH, 2);
    reg_write(REG_HEIGHT, 2);
    for (int i = 0; i < 5; i++) send_pixel('{8'hff, 8'h81, 8'h00, 8'h7e}, 1'b1, 8'd127);
    wait_drained();

    // size clamps, zero wavelength, octave saturation, max wavelength
    reg_write(REG_WIDTH, 0);
    reg_write(REG_HEIGHT, 13'h1fff);
    reg_write(REG_INV_X, 0);
    reg_write(REG_INV_Y, 24'hffffff);
    reg_write(REG_OCTAVES, 15);
    for (int i = 0; i < 4; i++) send_pixel($urandom, 1'b0, 8'd0);
    wait_drained();
    reg_write(REG_WIDTH, 13'd4096);
    reg_write(REG_HEIGHT, 1);
    reg_write(REG_INV_X, 24'hffffff);
    reg_write(REG_INV_Y, 1);
    reg_write(REG_OCTAVES, 8);
    for (int i = 0; i < 4; i++) send_pixel($urandom, 1'b0, 8'd0);
    wait_drained();

    // random phases; small frames so frame end shows up often
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin src_idle_pct = 56; snk_idle_pct = 23; end
      if (ph == 8) begin src_idle_pct = 0; snk_idle_pct = 0; end
      reg_write(REG_WIDTH, $urandom_range(1, 9));
      reg_write(REG_HEIGHT, $urandom_range(1, 6));
      reg_write(REG_INV_X, (ph % 3 == 0) ? $urandom_range(1, 24'hffffff)
                                         : $urandom_range(1, 24'h3ffff));
      reg_write(REG_INV_Y, (ph % 3 == 1) ? $urandom_range(1, 24'hffffff)
                                         : $urandom_range(1, 24'h3ffff));
      reg_write(REG_OCTAVES, (ph % 4 == 0) ? $urandom_range(0, 15)
                                           : $urandom_range(0, 3));
      phase_len = 100;
      for (int i = 0; i < phase_len; i++) begin
        px = $urandom;
        send_pixel(px, 1'b0, 8'd0);
      end
      wait_drained();
    end

    $display("Covered %0d words over directed corners and 12 random config phases,",
             word_cnt);
    $display("with source and sink stalls in both orders and without stalls.");
    if (fail_cnt == 0 && pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/vnpo_pkg.sv
sv/vnpo_regs.sv
sv/vnpo_ctrl.sv
sv/vnpo_dp.sv
sv/value_noise_pixel_overlay_unit.sv
sv/vnpo_checker.sv
bench/value_noise_pixel_overlay_unit_tb.sv
